// File: hw/rtl/hls_pkg.sv
// Shared types and constants for the histogram linear stretch block.
// Used by hls_div and histogram_linear_stretch; depends on nothing.
package hls_pkg;

    localparam int FRAME_PIXELS = 65536;
    localparam int INDEX_W      = 16;
    localparam int LEVEL_W      = 8;
    localparam int NUM_W        = 2 * LEVEL_W;

    // Only the addressable part of the frame gets storage.
    localparam int MEM_DEPTH = (FRAME_PIXELS < (1 << INDEX_W)) ? FRAME_PIXELS : (1 << INDEX_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int STEP_W    = $clog2(NUM_W);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [LEVEL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

// File: hw/rtl/hls_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on hls_pkg for widths and the request/response structs.
module hls_div import hls_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic               r_run,   n_run;
    logic               r_done,  n_done;
    logic [STEP_W-1:0]  r_step,  n_step;
    logic [NUM_W-1:0]   r_quo,   n_quo;
    logic [LEVEL_W-1:0] r_rem,   n_rem;
    logic [LEVEL_W-1:0] r_den,   n_den;
    logic [LEVEL_W:0]   trial;
    logic [LEVEL_W:0]   diff;
    logic               fits;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_run  = r_run;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_req.start) begin
            n_run  = 1'b1;
            n_step = '0;
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_run) begin
            // shift the numerator out and the quotient bit in
            n_quo = {r_quo[NUM_W-2:0], fits};
            n_rem = fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(NUM_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// File: hw/rtl/histogram_linear_stretch.sv
// Top level of the min/max linear contrast stretch: frame store, bounds, sequencer.
// Depends on hls_pkg and instantiates hls_div.
//
// Usage: present a transaction on i_operation, i_pixel_index, i_pixel_value and
// i_frame_start with start high; it is taken at the clock edge where busy is low.
// A load writes the pixel into the frame store and widens the running min/max
// (frame_start restarts both from that pixel); it produces no result and does
// not go busy, so loads can follow back to back.
// A read gives one result on o_stretched_level and o_flat_range, marked by
// o_valid for exactly one cycle. An in-range read passes through the
// synchronous frame store read, the bit-serial divider and a register for the
// result; the strobe rises as busy drops, so a new read is taken only once
// the last one is done. A flat or empty range skips the divider (the strobe
// is set from ST_READ); an index beyond the frame answers zero on the next
// cycle without going busy.
// The divider is the rate-setting unit. The receiver cannot stall: each result
// is shown once and must be taken then.
// Reset clears the bounds to min 255 / max 0 and the sequencer to idle; the
// frame store keeps no reset and holds garbage until loaded.
module histogram_linear_stretch import hls_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic [INDEX_W-1:0] i_pixel_index,
    input  logic [LEVEL_W-1:0] i_pixel_value,
    input  logic               i_frame_start,
    output logic               o_valid,
    output logic [LEVEL_W-1:0] o_stretched_level,
    output logic               o_flat_range
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [LEVEL_W-1:0] frame_mem [MEM_DEPTH];

    logic [1:0]         r_state, n_state;
    logic               r_valid, n_valid;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               r_flat,  n_flat;
    logic [LEVEL_W-1:0] r_low,   n_low;
    logic [LEVEL_W-1:0] r_high,  n_high;
    logic [LEVEL_W-1:0] r_rd_data;

    logic               accept;
    logic               in_range;
    logic [ADDR_W-1:0]  addr;
    logic               wr_en;
    logic               rd_en;
    logic [LEVEL_W-1:0] clamped;
    logic [LEVEL_W-1:0] offset;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign accept   = start && !busy;
    assign in_range = 32'(i_pixel_index) < 32'(FRAME_PIXELS);
    assign addr     = i_pixel_index[ADDR_W-1:0];
    assign wr_en    = accept && (i_operation == OP_LOAD) && in_range;
    assign rd_en    = accept && (i_operation == OP_READ) && in_range;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            frame_mem[addr] <= i_pixel_value;
        end
        if (rd_en) begin
            r_rd_data <= frame_mem[addr];
        end
    end

    // clamp a stale pixel into the current bounds
    always_comb begin
        clamped = r_rd_data;
        if (clamped < r_low) begin
            clamped = r_low;
        end
        if (clamped > r_high) begin
            clamped = r_high;
        end
        offset = clamped - r_low;
    end

    always_comb begin
        div_req.start = (r_state == ST_READ) && (r_high > r_low);
        // times full scale: x*256 - x
        div_req.num   = {offset, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, offset};
        div_req.den   = r_high - r_low;
    end

    hls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_level = r_level;
        n_flat  = r_flat;
        n_low   = r_low;
        n_high  = r_high;
        unique case (r_state)
            ST_IDLE: begin
                if (wr_en) begin
                    if (i_frame_start) begin
                        n_low  = i_pixel_value;
                        n_high = i_pixel_value;
                    end else begin
                        if (i_pixel_value < r_low) begin
                            n_low = i_pixel_value;
                        end
                        if (i_pixel_value > r_high) begin
                            n_high = i_pixel_value;
                        end
                    end
                end
                if (rd_en) begin
                    n_state = ST_READ;
                end else if (accept && (i_operation == OP_READ)) begin
                    // index beyond the frame: answer zero, not flat
                    n_valid = 1'b1;
                    n_level = '0;
                    n_flat  = 1'b0;
                end
            end
            ST_READ: begin
                if (r_high > r_low) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    n_level = '0;
                    n_flat  = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    n_level = div_rsp.quo[LEVEL_W-1:0];
                    n_flat  = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_low   <= LEVEL_MAX;
            r_high  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_low   <= n_low;
            r_high  <= n_high;
        end
        r_level <= n_level;
        r_flat  <= n_flat;
    end

    assign busy              = (r_state != ST_IDLE);
    assign o_valid           = r_valid;
    assign o_stretched_level = r_level;
    assign o_flat_range      = r_flat;

endmodule
